FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers on clk_i, with and without reset disable.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// checked outside reset only
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// checked at every edge, reset included
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_RST(lbl, prop, msg)
`endif

`endif

FILE: design/rkpq_pkg.sv
// ----------------------------------------------------------------------------
// rkpq_pkg
// Types, constants and the key function of the role keyed priority queue.
// ----------------------------------------------------------------------------
package rkpq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    MODE_INSERT = 1'b0,
    MODE_REMOVE = 1'b1
  } mode_e;

  typedef enum logic [2:0] {
    ROLE_BATSMAN    = 3'd0,
    ROLE_KEEPER     = 3'd1,
    ROLE_ALLROUNDER = 3'd2,
    ROLE_BOWLER     = 3'd3
  } role_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } ctrl_state_e;

  typedef struct packed {
    logic       mode;
    logic [15:0] entry_tag;
    logic [2:0]  role_code;
    logic [7:0]  batting_rating;
    logic [7:0]  bowling_rating;
  } pq_in_t;

  typedef struct packed {
    logic        result_valid;
    logic [15:0] out_tag;
    logic [7:0]  out_key;
    logic [4:0]  entry_count;
    logic        is_empty;
    logic        insert_dropped;
  } pq_out_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } pq_cmd_t;

  function automatic logic [7:0] key_of(logic [2:0] role, logic [7:0] bat,
                                        logic [7:0] bowl);
    logic [8:0] sum;
    sum = {1'b0, bat} + {1'b0, bowl};
    case (role)
      ROLE_BATSMAN, ROLE_KEEPER: key_of = bat;
      ROLE_ALLROUNDER:           key_of = sum[8:1];
      ROLE_BOWLER:               key_of = bowl;
      default:                   key_of = 8'd0;
    endcase
  endfunction

endpackage

FILE: design/rkpq_ctrl.sv
// ----------------------------------------------------------------------------
// rkpq_ctrl
// Command sequencer: takes a beat, runs one execute cycle, strobes the result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rkpq_ctrl
  import rkpq_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  output logic    busy_o,
  output logic    done_o,
  output pq_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= cmd_o.execute;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o.capture = 1'b0;
    cmd_o.execute = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.execute = 1'b1;
        state_d       = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy_o = (state_q != ST_IDLE);
  assign done_o = done_q;

  `ASSERT_CLK(a_exec_one_cycle, state_q == ST_EXEC |=> state_q == ST_IDLE, "execute overran")
  `ASSERT_CLK(a_done_after_exec, done_q |-> $past(state_q == ST_EXEC), "stray result strobe")
  `ASSERT_CLK(a_accept_goes_busy, cmd_o.capture |=> busy_o, "accepted beat not held busy")
  `ASSERT_RST(a_idle_in_reset, !rst_ni |=> !busy_o && !done_q, "not idle in reset")

endmodule

FILE: design/rkpq_datapath.sv
// ----------------------------------------------------------------------------
// rkpq_datapath
// Sorted slot chain with per-slot compare and shift, count and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rkpq_datapath
  import rkpq_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  pq_cmd_t cmd_i,
  input  pq_in_t  req_i,
  output pq_out_t rsp_o
);

  pq_in_t           in_q;
  pq_out_t          rsp_q, rsp_d;
  logic [15:0]      tag_q [QUEUE_DEPTH];
  logic [15:0]      tag_d [QUEUE_DEPTH];
  logic [7:0]       key_q [QUEUE_DEPTH];
  logic [7:0]       key_d [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] valid_q, valid_d;
  logic [CNT_W-1:0] count_q, count_d;

  // neighbour views of each slot
  logic [QUEUE_DEPTH-1:0] ge;
  logic [QUEUE_DEPTH-1:0] up_ge, up_valid, dn_valid;
  logic [15:0]      up_tag [QUEUE_DEPTH];
  logic [15:0]      dn_tag [QUEUE_DEPTH];
  logic [7:0]       up_key [QUEUE_DEPTH];
  logic [7:0]       dn_key [QUEUE_DEPTH];

  logic [7:0] new_key;
  logic       full, empty, do_insert, do_remove, drop_ins;

  assign new_key   = key_of(in_q.role_code, in_q.batting_rating, in_q.bowling_rating);
  assign full      = valid_q[QUEUE_DEPTH-1];
  assign empty     = !valid_q[0];
  assign drop_ins  = (in_q.mode == MODE_INSERT) && full;
  assign do_insert = cmd_i.execute && (in_q.mode == MODE_INSERT) && !full;
  assign do_remove = cmd_i.execute && (in_q.mode == MODE_REMOVE) && !empty;

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_slot
    assign ge[g] = valid_q[g] && (key_q[g] >= new_key);
    if (g == 0) begin : g_first
      assign up_ge[g]    = 1'b1;
      assign up_valid[g] = 1'b0;
      assign up_tag[g]   = tag_q[g];
      assign up_key[g]   = key_q[g];
    end else begin : g_mid_up
      assign up_ge[g]    = ge[g-1];
      assign up_valid[g] = valid_q[g-1];
      assign up_tag[g]   = tag_q[g-1];
      assign up_key[g]   = key_q[g-1];
    end
    if (g == QUEUE_DEPTH - 1) begin : g_last
      assign dn_valid[g] = 1'b0;
      assign dn_tag[g]   = tag_q[g];
      assign dn_key[g]   = key_q[g];
    end else begin : g_mid_dn
      assign dn_valid[g] = valid_q[g+1];
      assign dn_tag[g]   = tag_q[g+1];
      assign dn_key[g]   = key_q[g+1];
    end
  end

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      tag_d[i]   = tag_q[i];
      key_d[i]   = key_q[i];
      valid_d[i] = valid_q[i];
      if (do_insert) begin
        if (!ge[i] && up_ge[i]) begin
          // first slot below the equal-or-higher run takes the new entry
          tag_d[i]   = in_q.entry_tag;
          key_d[i]   = new_key;
          valid_d[i] = 1'b1;
        end else if (!ge[i]) begin
          tag_d[i]   = up_tag[i];
          key_d[i]   = up_key[i];
          valid_d[i] = up_valid[i];
        end
      end else if (do_remove) begin
        tag_d[i]   = dn_tag[i];
        key_d[i]   = dn_key[i];
        valid_d[i] = dn_valid[i];
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (do_insert) begin
      count_d = CNT_W'(count_q + 1'b1);
    end else if (do_remove) begin
      count_d = CNT_W'(count_q - 1'b1);
    end
    rsp_d.result_valid   = do_remove;
    rsp_d.out_tag        = do_remove ? tag_q[0] : 16'd0;
    rsp_d.out_key        = do_remove ? key_q[0] : 8'd0;
    rsp_d.entry_count    = 5'(count_d);
    rsp_d.is_empty       = (count_d == '0);
    rsp_d.insert_dropped = drop_ins;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
    end else begin
      valid_q <= valid_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      in_q <= req_i;
    end
    if (cmd_i.execute) begin
      rsp_q <= rsp_d;
    end
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      tag_q[i] <= tag_d[i];
      key_q[i] <= key_d[i];
    end
  end

  assign rsp_o = rsp_q;

  `ASSERT_CLK(a_count_matches_valid, $countones(valid_q) == count_q, "count off valid bits")
  `ASSERT_CLK(a_head_ordered, valid_q[1] |-> key_q[0] >= key_q[1], "head slots out of order")
  `ASSERT_CLK(a_full_holds, cmd_i.execute && drop_ins |=> $stable(count_q), "full insert moved")

endmodule

FILE: design/role_keyed_priority_queue.sv
// ----------------------------------------------------------------------------
// role_keyed_priority_queue
// Bounded max-priority queue in descending key order, key formed from role and ratings.
// ----------------------------------------------------------------------------
// done_o and the result are registered from the execute state that follows
// the edge that accepts a beat. A new beat is not taken while busy; busy is
// high for the single execute cycle in which every slot compares with the new
// key and shifts in place.
// The result strobe lasts one cycle; a new beat may be taken in that cycle.
// Reset clears the count and the slot valid bits at once; no clearing pass.

module role_keyed_priority_queue
  import rkpq_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  output logic    busy,
  input  pq_in_t  req_i,
  output logic    done_o,
  output pq_out_t rsp_o
);

  pq_cmd_t cmd;

  rkpq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .done_o  (done_o),
    .cmd_o   (cmd)
  );

  rkpq_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (req_i),
    .rsp_o  (rsp_o)
  );

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the role keyed priority queue. Commands enter on the
// start/busy handshake from a backlog. Each accepted beat is run through a
// sorted-slot model of the queue. The result beat that follows is compared
// field by field with the oldest prediction. Directed beats cover the key
// extremes, unknown roles, ties, a full queue and an empty queue. Random
// fill and drain bursts follow, under three sender idling profiles.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rkpq_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_BEATS = 1200;

  typedef struct {
    pq_in_t      beat;
    int unsigned idle_pct;
  } queued_cmd_t;

  logic    clk_i  = 1'b0;
  logic    rst_ni = 1'b0;
  logic    start  = 1'b0;
  pq_in_t  req_i  = '0;
  logic    busy;
  logic    done_o;
  pq_out_t rsp_o;

  queued_cmd_t cmd_backlog[$];
  pq_out_t     due_responses[$];

  // model of the slot array: slot 0 holds the highest key
  logic [15:0] model_tag [QUEUE_DEPTH];
  logic [7:0]  model_key [QUEUE_DEPTH];
  int          model_count = 0;

  int          mismatches  = 0;
  int          cycle_count = 0;

  role_keyed_priority_queue dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  always #6ns clk_i = ~clk_i;

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  function automatic logic [7:0] rank_key(logic [2:0] role, logic [7:0] bat,
                                          logic [7:0] bowl);
    int total;
    total = int'(bat) + int'(bowl);
    case (role)
      ROLE_BATSMAN, ROLE_KEEPER: return bat;
      ROLE_ALLROUNDER:           return 8'(total / 2);
      ROLE_BOWLER:               return bowl;
      default:                   return 8'd0;
    endcase
  endfunction

  function automatic pq_out_t predict_queue_op(pq_in_t cmd);
    pq_out_t     r;
    logic [7:0]  k;
    int          pos;
    r = '0;
    if (cmd.mode == MODE_INSERT) begin
      if (model_count >= QUEUE_DEPTH) begin
        r.insert_dropped = 1'b1;
      end else begin
        k   = rank_key(cmd.role_code, cmd.batting_rating, cmd.bowling_rating);
        pos = 0;
        // equal keys stay ahead, so ties leave in arrival order
        while (pos < model_count && model_key[pos] >= k) pos++;
        for (int i = model_count; i > pos; i--) begin
          model_tag[i] = model_tag[i-1];
          model_key[i] = model_key[i-1];
        end
        model_tag[pos] = cmd.entry_tag;
        model_key[pos] = k;
        model_count++;
      end
    end else if (model_count > 0) begin
      r.result_valid = 1'b1;
      r.out_tag      = model_tag[0];
      r.out_key      = model_key[0];
      for (int i = 1; i < model_count; i++) begin
        model_tag[i-1] = model_tag[i];
        model_key[i-1] = model_key[i];
      end
      model_count--;
    end
    r.entry_count = 5'(model_count);
    r.is_empty    = (model_count == 0);
    return r;
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got,
             want);
  endtask

  task automatic queue_command(mode_e mode, logic [15:0] tag, logic [2:0] role,
                               logic [7:0] bat, logic [7:0] bowl, int unsigned idle);
    queued_cmd_t q;
    q.beat.mode           = mode;
    q.beat.entry_tag      = tag;
    q.beat.role_code      = role;
    q.beat.batting_rating = bat;
    q.beat.bowling_rating = bowl;
    q.idle_pct            = idle;
    cmd_backlog.push_back(q);
  endtask

  // driver: present the front of the backlog, hold it until the beat is taken
  always @(posedge clk_i) begin : drive
    logic took;
    took = start && !busy;
    if (took) begin
      due_responses.push_back(predict_queue_op(req_i));
      void'(cmd_backlog.pop_front());
    end
    if (!rst_ni) begin
      start <= 1'b0;
    end else if (start && !took) begin
      // hold the beat
    end else if (cmd_backlog.size() > 0 &&
                 $urandom_range(99) >= cmd_backlog[0].idle_pct) begin
      start <= 1'b1;
      req_i <= cmd_backlog[0].beat;
    end else begin
      start <= 1'b0;
    end
  end

  // monitor: every strobed result retires the oldest prediction
  always @(posedge clk_i) begin : watch
    pq_out_t want;
    if (rst_ni && done_o) begin
      if (due_responses.size() == 0) begin
        flag_mismatch("result beat with nothing due", 32'd1, 32'd0);
      end else begin
        want = due_responses.pop_front();
        if (rsp_o.result_valid !== want.result_valid)
          flag_mismatch("result_valid", 32'(rsp_o.result_valid),
                        32'(want.result_valid));
        if (rsp_o.out_tag !== want.out_tag)
          flag_mismatch("out_tag", 32'(rsp_o.out_tag), 32'(want.out_tag));
        if (rsp_o.out_key !== want.out_key)
          flag_mismatch("out_key", 32'(rsp_o.out_key), 32'(want.out_key));
        if (rsp_o.entry_count !== want.entry_count)
          flag_mismatch("entry_count", 32'(rsp_o.entry_count),
                        32'(want.entry_count));
        if (rsp_o.is_empty !== want.is_empty)
          flag_mismatch("is_empty", 32'(rsp_o.is_empty), 32'(want.is_empty));
        if (rsp_o.insert_dropped !== want.insert_dropped)
          flag_mismatch("insert_dropped", 32'(rsp_o.insert_dropped),
                        32'(want.insert_dropped));
      end
    end
  end

  initial begin : timeout
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("FAIL role_keyed_priority_queue");
    $finish;
  end

  initial begin : stimulus
    int          n;
    int          burst;
    int unsigned idle;
    logic [2:0]  role;
    logic [7:0]  bat;
    logic [7:0]  bowl;

    // directed: empty remove, key extremes, floor of the mean, unknown roles,
    // ties, fill to full, a dropped insert, then a couple of removes
    queue_command(MODE_REMOVE, 16'hFFFF, 3'd7, 8'hFF, 8'hFF, 17);
    queue_command(MODE_INSERT, 16'hFFFF, 3'd0, 8'd255, 8'd0,   17);
    queue_command(MODE_INSERT, 16'h0000, 3'd1, 8'd0,   8'd255, 17);
    queue_command(MODE_INSERT, 16'h0001, 3'd2, 8'd255, 8'd255, 17);
    queue_command(MODE_INSERT, 16'h0002, 3'd2, 8'd255, 8'd0,   17);
    queue_command(MODE_INSERT, 16'h0003, 3'd2, 8'd0,   8'd1,   17);
    queue_command(MODE_INSERT, 16'h8000, 3'd3, 8'd0,   8'd255, 17);
    queue_command(MODE_INSERT, 16'h4004, 3'd3, 8'd255, 8'd0,   17);
    queue_command(MODE_INSERT, 16'h2005, 3'd4, 8'd200, 8'd200, 17);
    queue_command(MODE_INSERT, 16'h1006, 3'd5, 8'd255, 8'd255, 17);
    queue_command(MODE_INSERT, 16'h0807, 3'd6, 8'd128, 8'd1,   17);
    queue_command(MODE_INSERT, 16'h0408, 3'd7, 8'd77,  8'd99,  17);
    queue_command(MODE_INSERT, 16'h0209, 3'd0, 8'd127, 8'd3,   17);
    queue_command(MODE_INSERT, 16'h010A, 3'd2, 8'd1,   8'd2,   17);
    queue_command(MODE_INSERT, 16'h00FB, 3'd1, 8'd128, 8'd0,   17);
    queue_command(MODE_INSERT, 16'hAAAC, 3'd3, 8'd7,   8'd1,   17);
    queue_command(MODE_INSERT, 16'h555D, 3'd0, 8'h55,  8'hAA,  17);
    queue_command(MODE_INSERT, 16'hBEEF, 3'd0, 8'd255, 8'd255, 17);
    queue_command(MODE_REMOVE, 16'h5A5A, 3'd2, 8'h0F,  8'hF0,  17);
    queue_command(MODE_REMOVE, 16'hA5A5, 3'd5, 8'hF0,  8'h0F,  17);

    // random: fill and drain bursts so the queue keeps hitting full and empty
    n = 0;
    while (n < RANDOM_BEATS) begin
      idle = (n < RANDOM_BEATS / 3) ? 17 : ((n < 2 * RANDOM_BEATS / 3) ? 79 : 0);
      if ($urandom_range(9) == 0) begin
        queue_command(mode_e'($urandom_range(1)), 16'($urandom), 3'($urandom_range(7)),
                      8'($urandom), 8'($urandom), idle);
        n++;
      end else begin
        burst = $urandom_range(20, 1);
        for (int i = 0; i < burst; i++) begin
          role = ($urandom_range(4) == 0) ? 3'($urandom_range(7, 4))
                                          : 3'($urandom_range(3));
          // narrow ratings often, to force equal keys
          if ($urandom_range(1) == 0) begin
            bat  = 8'($urandom_range(3) * 85);
            bowl = 8'($urandom_range(3) * 85);
          end else begin
            bat  = 8'($urandom);
            bowl = 8'($urandom);
          end
          queue_command(MODE_INSERT, 16'($urandom), role, bat, bowl, idle);
        end
        n += burst;
        burst = $urandom_range(20, 1);
        for (int i = 0; i < burst; i++)
          queue_command(MODE_REMOVE, 16'($urandom), 3'($urandom_range(7)),
                        8'($urandom), 8'($urandom), idle);
        n += burst;
      end
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_backlog.size() != 0) @(posedge clk_i);
    while (due_responses.size() != 0) @(posedge clk_i);
    // drain: catch any stray strobe after the last result
    repeat (6) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("PASS role_keyed_priority_queue");
    end else begin
      $display("FAIL role_keyed_priority_queue");
    end
    $finish;
  end

endmodule
